[hw/rtl/polygon_area_centroid_top_assert.svh]
// Assertion macros for the polygon area and centroid block.
`ifndef POLYGON_AREA_CENTROID_TOP_ASSERT_SVH
`define POLYGON_AREA_CENTROID_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PAC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define PAC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PAC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PAC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[hw/rtl/pac_pkg.sv]
package pac_pkg;

    localparam int COORD_W = 16;
    localparam int SUM_W   = COORD_W + 1;
    localparam int CRS_W   = 2 * COORD_W + 1;
    localparam int PROD_W  = SUM_W + CRS_W;
    localparam int AREA_W  = 46;
    localparam int MOM_W   = 64;
    localparam int OUT_W   = 24;

    localparam int MAX_VERTICES_DEF = 4096;
    localparam int COORD_BITS_DEF   = 16;
    localparam int FRAC_BITS_DEF    = 8;

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

endpackage

[hw/rtl/pac_mul.sv]
module pac_mul
    import pac_pkg::*;
(
    input  logic                     aclk,
    input  logic signed [SUM_W-1:0]  mul_a,
    input  logic signed [CRS_W-1:0]  mul_b,
    output logic signed [PROD_W-1:0] prod_reg
);

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

endmodule

[hw/rtl/pac_div.sv]
module pac_div
    import pac_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [MOM_W-1:0]  num,
    input  logic signed [AREA_W-1:0] area,
    output logic                     done_reg,
    output logic signed [OUT_W-1:0]  quot_reg
);

    localparam int NUM_W = MOM_W + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W);
    localparam int DEN_W = AREA_W + 1;
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(NUM_W - 1);
    localparam logic [NUM_W-1:0] POS_LIM  = NUM_W'((64'd1 << (OUT_W - 1)) - 64'd1);
    localparam logic [NUM_W-1:0] NEG_LIM  = NUM_W'(64'd1 << (OUT_W - 1));

    typedef enum logic [1:0] {
        D_IDLE,
        D_PREP,
        D_RUN,
        D_FIN
    } div_state_t;

    div_state_t        state_reg;
    logic              neg_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [AREA_W-1:0] amag_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic [MOM_W-1:0]  nmag;
    logic [AREA_W-1:0] amag;
    logic [DEN_W:0]    rem_sh;
    logic [DEN_W:0]    diff;
    logic              ge;

    assign nmag   = num[MOM_W-1] ? MOM_W'(-num) : MOM_W'(num);
    assign amag   = area[AREA_W-1] ? AREA_W'(-area) : AREA_W'(area);
    assign rem_sh = {rem_reg, num_reg[NUM_W-1]};
    assign diff   = rem_sh - {1'b0, den_reg};
    assign ge     = (rem_sh >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE: begin
                    if (start) begin
                        neg_reg   <= num[MOM_W-1] ^ area[AREA_W-1];
                        num_reg   <= NUM_W'(nmag) << FRAC_BITS;
                        amag_reg  <= amag;
                        state_reg <= D_PREP;
                    end
                end
                D_PREP: begin
                    // divisor is three times the magnitude of the doubled area
                    den_reg   <= {amag_reg, 1'b0} + {1'b0, amag_reg};
                    rem_reg   <= '0;
                    cnt_reg   <= LAST_BIT;
                    state_reg <= D_RUN;
                end
                D_RUN: begin
                    rem_reg <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                    num_reg <= {num_reg[NUM_W-2:0], ge};
                    if (cnt_reg == '0) begin
                        state_reg <= D_FIN;
                    end else begin
                        cnt_reg <= cnt_reg - CNT_W'(1);
                    end
                end
                D_FIN: begin
                    if (!neg_reg) begin
                        quot_reg <= (num_reg > POS_LIM) ? OUT_MAX
                                                        : $signed(num_reg[OUT_W-1:0]);
                    end else begin
                        quot_reg <= (num_reg > NEG_LIM) ? OUT_MIN
                                                        : $signed(OUT_W'(-num_reg[OUT_W-1:0]));
                    end
                    done_reg  <= 1'b1;
                    state_reg <= D_IDLE;
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

endmodule

[hw/rtl/polygon_area_centroid_top.sv]
// Channel  Dir  Ports                                             Request
// s_       in   s_vertex_x s_vertex_y s_ring_end s_set_end        one vertex
// m_       out  m_centroid_x m_centroid_y m_twice_area            one set result
//               m_area_zero m_count_overflow
// First vertex of a ring: stored only. Each edge: states P1, P2, C, MX, MY and AY,
// using the shared multiplier. Set end: plus two divides (bit-serial divider), skipped
// when the area is zero, then the result register is loaded in ST_OUT.
// aresetn is synchronous, active low; it clears the sequencer and the sums.
// A pending result does not block input; a new result waits until the old one is taken.
`include "polygon_area_centroid_top_assert.svh"

module polygon_area_centroid_top
    import pac_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [15:0]       s_vertex_x,
    input  logic signed [15:0]       s_vertex_y,
    input  logic                     s_ring_end,
    input  logic                     s_set_end,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [OUT_W-1:0]  m_centroid_x,
    output logic signed [OUT_W-1:0]  m_centroid_y,
    output logic signed [AREA_W-1:0] m_twice_area,
    output logic                     m_area_zero,
    output logic                     m_count_overflow
);

    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_P1,
        ST_P2,
        ST_C,
        ST_MX,
        ST_MY,
        ST_AY,
        ST_DIVX,
        ST_WAITX,
        ST_DIVY,
        ST_WAITY,
        ST_OUT
    } pac_state_t;

    pac_state_t                state_reg;
    logic                      started_reg;
    logic                      close_reg;
    logic                      send_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      ovf_reg;
    logic signed [COORD_W-1:0] first_x_reg, first_y_reg;
    logic signed [COORD_W-1:0] prev_x_reg, prev_y_reg;
    logic signed [COORD_W-1:0] ex0_reg, ey0_reg, ex1_reg, ey1_reg;
    logic signed [CRS_W-1:0]   p1_reg;
    logic signed [CRS_W-1:0]   c_reg;
    logic signed [AREA_W-1:0]  cross_reg;
    logic signed [MOM_W-1:0]   momx_reg, momy_reg;
    logic signed [OUT_W-1:0]   qx_reg, qy_reg;

    logic                      m_valid_reg;
    logic signed [OUT_W-1:0]   m_cx_reg, m_cy_reg;
    logic signed [AREA_W-1:0]  m_area_reg;
    logic                      m_zero_reg;
    logic                      m_ovf_reg;

    logic signed [COORD_W-1:0] xs, ys;
    logic signed [SUM_W-1:0]   sum_x, sum_y;
    logic signed [SUM_W-1:0]   mul_a;
    logic signed [CRS_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [CRS_W-1:0]   c_calc;
    logic                      area_zero;
    logic                      div_start;
    logic signed [MOM_W-1:0]   div_num;
    logic                      div_done;
    logic signed [OUT_W-1:0]   div_q;
    logic                      close_in;

    assign xs        = COORD_W'($signed(s_vertex_x[COORD_BITS-1:0]));
    assign ys        = COORD_W'($signed(s_vertex_y[COORD_BITS-1:0]));
    assign close_in  = s_ring_end | s_set_end;
    assign sum_x     = SUM_W'(ex0_reg) + SUM_W'(ex1_reg);
    assign sum_y     = SUM_W'(ey0_reg) + SUM_W'(ey1_reg);
    assign c_calc    = p1_reg - $signed(prod[CRS_W-1:0]);
    assign area_zero = (cross_reg == '0);
    assign div_start = (state_reg == ST_DIVX) || (state_reg == ST_DIVY);
    assign div_num   = (state_reg == ST_DIVX) ? momx_reg : momy_reg;
    assign s_ready   = (state_reg == ST_IDLE);

    always_comb begin
        mul_a = sum_x;
        mul_b = c_reg;
        unique case (state_reg)
            ST_P1: begin
                mul_a = SUM_W'(ex0_reg);
                mul_b = CRS_W'(ey1_reg);
            end
            ST_P2: begin
                mul_a = SUM_W'(ex1_reg);
                mul_b = CRS_W'(ey0_reg);
            end
            ST_MY: mul_a = sum_y;
            default: mul_a = sum_x;
        endcase
    end

    pac_mul u_mul (
        .aclk     (aclk),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .prod_reg (prod)
    );

    pac_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num      (div_num),
        .area     (cross_reg),
        .done_reg (div_done),
        .quot_reg (div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            started_reg <= 1'b0;
            close_reg   <= 1'b0;
            send_reg    <= 1'b0;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            cross_reg   <= '0;
            momx_reg    <= '0;
            momy_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        if (cnt_reg >= CNT_W'(MAX_VERTICES)) begin
                            ovf_reg <= 1'b1;
                        end else begin
                            cnt_reg <= cnt_reg + CNT_W'(1);
                        end
                        prev_x_reg  <= xs;
                        prev_y_reg  <= ys;
                        send_reg    <= s_set_end;
                        started_reg <= !close_in;
                        if (started_reg) begin
                            ex0_reg   <= prev_x_reg;
                            ey0_reg   <= prev_y_reg;
                            ex1_reg   <= xs;
                            ey1_reg   <= ys;
                            close_reg <= close_in;
                            state_reg <= ST_P1;
                        end else begin
                            // first vertex of a ring; a lone-vertex ring adds no edge
                            first_x_reg <= xs;
                            first_y_reg <= ys;
                            if (s_set_end) begin
                                state_reg <= area_zero ? ST_OUT : ST_DIVX;
                            end
                        end
                    end
                end
                ST_P1: state_reg <= ST_P2;
                ST_P2: begin
                    p1_reg    <= $signed(prod[CRS_W-1:0]);
                    state_reg <= ST_C;
                end
                ST_C: begin
                    c_reg     <= c_calc;
                    cross_reg <= cross_reg + AREA_W'(c_calc);
                    state_reg <= ST_MX;
                end
                ST_MX: state_reg <= ST_MY;
                ST_MY: begin
                    momx_reg  <= momx_reg + MOM_W'(prod);
                    state_reg <= ST_AY;
                end
                ST_AY: begin
                    momy_reg <= momy_reg + MOM_W'(prod);
                    if (close_reg) begin
                        // closing edge back to the ring's first vertex
                        close_reg <= 1'b0;
                        ex0_reg   <= prev_x_reg;
                        ey0_reg   <= prev_y_reg;
                        ex1_reg   <= first_x_reg;
                        ey1_reg   <= first_y_reg;
                        state_reg <= ST_P1;
                    end else if (send_reg) begin
                        state_reg <= area_zero ? ST_OUT : ST_DIVX;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_DIVX: state_reg <= ST_WAITX;
                ST_WAITX: begin
                    if (div_done) begin
                        qx_reg    <= div_q;
                        state_reg <= ST_DIVY;
                    end
                end
                ST_DIVY: state_reg <= ST_WAITY;
                ST_WAITY: begin
                    if (div_done) begin
                        qy_reg    <= div_q;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_cx_reg    <= area_zero ? '0 : qx_reg;
                        m_cy_reg    <= area_zero ? '0 : qy_reg;
                        m_area_reg  <= cross_reg;
                        m_zero_reg  <= area_zero;
                        m_ovf_reg   <= ovf_reg;
                        cross_reg   <= '0;
                        momx_reg    <= '0;
                        momy_reg    <= '0;
                        cnt_reg     <= '0;
                        ovf_reg     <= 1'b0;
                        send_reg    <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_centroid_x     = m_cx_reg;
    assign m_centroid_y     = m_cy_reg;
    assign m_twice_area     = m_area_reg;
    assign m_area_zero      = m_zero_reg;
    assign m_count_overflow = m_ovf_reg;

    `PAC_ASSERT_IMP(a_done_in_wait, aclk, aresetn, div_done, state_reg == ST_WAITX || state_reg == ST_WAITY)
    `PAC_ASSERT_IMP(a_zero_centroid, aclk, aresetn, m_valid_reg && m_zero_reg, m_cx_reg == '0 && m_cy_reg == '0)
    `PAC_ASSERT_IMP(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= CNT_W'(MAX_VERTICES))
    `PAC_ASSERT_IMP(a_ovf_full, aclk, aresetn, ovf_reg, cnt_reg == CNT_W'(MAX_VERTICES))
    `PAC_ASSERT_NXT(a_edge_busy, aclk, aresetn, s_valid && s_ready && started_reg, !s_ready)

endmodule

[test/polygon_area_centroid_top_tb.sv]
module polygon_area_centroid_top_tb;
    import pac_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 1100;
    localparam int TAIL_CYCLES  = 200;
    localparam int HOLD_CYCLES  = 500;
    localparam int HOLD_AFTER   = 12;
    localparam int IDLE_PCT     = 21;

    localparam longint CEN_HI   = OUT_MAX;
    localparam longint CEN_LO   = OUT_MIN;
    localparam longint Q_LIMIT  = longint'(1) << OUT_W;
    localparam longint FRAC_ONE = longint'(1) << FRAC_BITS_DEF;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               rend;
        logic               send;
    } vertex_req_t;

    typedef struct packed {
        logic signed [OUT_W-1:0]  cx;
        logic signed [OUT_W-1:0]  cy;
        logic signed [AREA_W-1:0] area;
        logic                     zero;
        logic                     ovf;
    } set_result_t;

    typedef struct packed {
        vertex_req_t v;
        logic        typed;
        set_result_t want;
    } dir_row_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic signed [15:0]       s_vertex_x;
    logic signed [15:0]       s_vertex_y;
    logic                     s_ring_end;
    logic                     s_set_end;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [OUT_W-1:0]  m_centroid_x;
    logic signed [OUT_W-1:0]  m_centroid_y;
    logic signed [AREA_W-1:0] m_twice_area;
    logic                     m_area_zero;
    logic                     m_count_overflow;

    polygon_area_centroid_top uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_vertex_x       (s_vertex_x),
        .s_vertex_y       (s_vertex_y),
        .s_ring_end       (s_ring_end),
        .s_set_end        (s_set_end),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_centroid_x     (m_centroid_x),
        .m_centroid_y     (m_centroid_y),
        .m_twice_area     (m_twice_area),
        .m_area_zero      (m_area_zero),
        .m_count_overflow (m_count_overflow)
    );

    // shoelace predictor state
    logic signed [15:0]  ring_x0, ring_y0, last_x, last_y;
    bit                  ring_open;
    logic [AREA_W-1:0]   area2_acc;
    logic [MOM_W-1:0]    momx_acc, momy_acc;
    int unsigned         vtx_count;
    bit                  count_ovf;

    set_result_t due_centroids[$];
    dir_row_t    dir_rows[$];
    int          errors;
    int          results_seen;
    int          items_sent;
    int          cycle_count;
    bit          quiet;

    function automatic void reset_accumulators();
        ring_x0   = '0;
        ring_y0   = '0;
        last_x    = '0;
        last_y    = '0;
        ring_open = 1'b0;
        area2_acc = '0;
        momx_acc  = '0;
        momy_acc  = '0;
        vtx_count = 0;
        count_ovf = 1'b0;
    endfunction

    function automatic void accumulate_edge(longint x0, longint y0, longint x1, longint y1);
        longint c;
        c = x0 * y1 - x1 * y0;
        area2_acc = area2_acc + AREA_W'(c);
        momx_acc  = momx_acc + MOM_W'((x0 + x1) * c);
        momy_acc  = momy_acc + MOM_W'((y0 + y1) * c);
    endfunction

    // trunc(n * 2^FRAC / d), saturated to the output range
    function automatic logic [OUT_W-1:0] scale_quotient(longint n, longint d);
        longint q, r, v;
        q = n / d;
        r = n % d;
        if (q > Q_LIMIT) begin
            v = CEN_HI;
        end else if (q < -Q_LIMIT) begin
            v = CEN_LO;
        end else begin
            v = q * FRAC_ONE + (r * FRAC_ONE) / d;
            if (v > CEN_HI) v = CEN_HI;
            if (v < CEN_LO) v = CEN_LO;
        end
        return OUT_W'(v);
    endfunction

    function automatic bit predict_vertex(input vertex_req_t v, output set_result_t r);
        longint x, y, a2, d;
        x = $signed(v.x);
        y = $signed(v.y);
        if (vtx_count >= MAX_VERTICES_DEF) count_ovf = 1'b1;
        else vtx_count++;
        if (!ring_open) begin
            ring_x0   = v.x;
            ring_y0   = v.y;
            ring_open = 1'b1;
        end else begin
            accumulate_edge(last_x, last_y, x, y);
        end
        last_x = v.x;
        last_y = v.y;
        if (v.rend || v.send) begin
            accumulate_edge(x, y, ring_x0, ring_y0);
            ring_open = 1'b0;
        end
        if (!v.send) return 1'b0;
        a2 = $signed(area2_acc);
        if (a2 == 0) begin
            r.cx   = '0;
            r.cy   = '0;
            r.zero = 1'b1;
        end else begin
            d      = a2 * 3;
            r.cx   = scale_quotient($signed(momx_acc), d);
            r.cy   = scale_quotient($signed(momy_acc), d);
            r.zero = 1'b0;
        end
        r.area = area2_acc;
        r.ovf  = count_ovf;
        reset_accumulators();
        return 1'b1;
    endfunction

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic push_vertex(input vertex_req_t v, input bit typed, input set_result_t want);
        set_result_t got;
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_vertex_x <= v.x;
        s_vertex_y <= v.y;
        s_ring_end <= v.rend;
        s_set_end  <= v.send;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        if (predict_vertex(v, got)) begin
            due_centroids.insert(due_centroids.size(), typed ? want : got);
        end
        @(negedge aclk);
    endtask

    task automatic send_xy(input int x, input int y, input bit re, input bit se);
        vertex_req_t v;
        v.x    = 16'(x);
        v.y    = 16'(y);
        v.rend = re;
        v.send = se;
        push_vertex(v, 1'b0, '0);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (due_centroids.size() != 0);
    endtask

    task automatic add_row(input int x, input int y, input bit re, input bit se);
        dir_row_t r;
        r        = '0;
        r.v.x    = 16'(x);
        r.v.y    = 16'(y);
        r.v.rend = re;
        r.v.send = se;
        dir_rows.insert(dir_rows.size(), r);
    endtask

    task automatic typed_last(input int cx, input int cy, input longint area, input bit zero);
        int idx;
        idx                     = dir_rows.size() - 1;
        dir_rows[idx].typed     = 1'b1;
        dir_rows[idx].want.cx   = OUT_W'(cx);
        dir_rows[idx].want.cy   = OUT_W'(cy);
        dir_rows[idx].want.area = AREA_W'(area);
        dir_rows[idx].want.zero = zero;
        dir_rows[idx].want.ovf  = 1'b0;
    endtask

    function automatic int rnd_coord(int span);
        if (span == 0) return int'($urandom_range(0, 65535)) - 32768;
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(0, 3))
            0: return -32768;
            1: return 32767;
            2: return 0;
            default: return -1;
        endcase
    endfunction

    task automatic send_random_set();
        int xs[8], ys[8];
        int rings, n, mode, span, lx, hx, ly, hy, t;
        bit re, se, last;
        rings = ($urandom_range(0, 9) < 7) ? 1 : $urandom_range(2, 3);
        for (int k = 0; k < rings; k++) begin
            mode = $urandom_range(0, 3);
            if (mode == 0) begin
                span = $urandom_range(0, 1) ? 0 : 500;
                lx = rnd_coord(span);
                hx = rnd_coord(span);
                ly = rnd_coord(span);
                hy = rnd_coord(span);
                if (lx > hx) begin
                    t = lx; lx = hx; hx = t;
                end
                if (ly > hy) begin
                    t = ly; ly = hy; hy = t;
                end
                n = 4;
                xs[0] = lx; ys[0] = ly;
                xs[1] = hx; ys[1] = ly;
                xs[2] = hx; ys[2] = hy;
                xs[3] = lx; ys[3] = hy;
                // later rings (holes) run clockwise in three of four cases
                if (k != 0 && $urandom_range(0, 3) != 0) begin
                    xs[1] = lx; ys[1] = hy;
                    xs[3] = hx; ys[3] = ly;
                end
            end else begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++) begin
                    if (mode == 1) begin
                        xs[i] = rnd_coord(200);
                        ys[i] = rnd_coord(200);
                    end else if (mode == 2) begin
                        xs[i] = rnd_coord(0);
                        ys[i] = rnd_coord(0);
                    end else begin
                        xs[i] = pick_extreme();
                        ys[i] = pick_extreme();
                    end
                end
            end
            for (int i = 0; i < n; i++) begin
                last = (k == rings - 1) && (i == n - 1);
                re   = (i == n - 1);
                se   = last;
                if (last) re = $urandom_range(0, 1);
                if ($urandom_range(0, 99) < 4) re = ~re;
                if ($urandom_range(0, 99) < 2) se = 1'b1;
                send_xy(xs[i], ys[i], re, se);
            end
        end
    endtask

    // receiver: random back-pressure plus one long hold while the sender keeps going
    initial begin
        int hold_left;
        bit hold_done;
        m_ready   = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else begin
                m_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        set_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (due_centroids.size() == 0) begin
                $display("%0t: result with no request pending", $time);
                errors++;
            end else begin
                want = due_centroids.pop_front();
                if (m_centroid_x !== want.cx) begin
                    $display("%0t: centroid_x expected %0d got %0d", $time, want.cx, m_centroid_x);
                    errors++;
                end
                if (m_centroid_y !== want.cy) begin
                    $display("%0t: centroid_y expected %0d got %0d", $time, want.cy, m_centroid_y);
                    errors++;
                end
                if (m_twice_area !== want.area) begin
                    $display("%0t: twice_area expected %0d got %0d", $time, want.area,
                             m_twice_area);
                    errors++;
                end
                if (m_area_zero !== want.zero) begin
                    $display("%0t: area_zero expected %0b got %0b", $time, want.zero,
                             m_area_zero);
                    errors++;
                end
                if (m_count_overflow !== want.ovf) begin
                    $display("%0t: count_overflow expected %0b got %0b", $time, want.ovf,
                             m_count_overflow);
                    errors++;
                end
            end
        end
    end

    initial begin
        int rand_start;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_vertex_x = '0;
        s_vertex_y = '0;
        s_ring_end = 1'b0;
        s_set_end  = 1'b0;
        errors       = 0;
        results_seen = 0;
        items_sent   = 0;
        cycle_count  = 0;
        quiet        = 1'b0;
        reset_accumulators();

        // lone vertex right after reset: zero area
        add_row(-32768, 32767, 1'b0, 1'b1);
        typed_last(0, 0, 0, 1'b1);
        // set end closes an open ring
        add_row(0, 0, 1'b0, 1'b0);
        add_row(3, 0, 1'b0, 1'b0);
        add_row(0, 3, 1'b0, 1'b1);
        typed_last(256, 256, 9, 1'b0);
        // full-range square
        add_row(-32768, -32768, 1'b0, 1'b0);
        add_row(32767, -32768, 1'b0, 1'b0);
        add_row(32767, 32767, 1'b0, 1'b0);
        add_row(-32768, 32767, 1'b1, 1'b1);
        // outer ring, one-vertex ring, clockwise hole
        add_row(0, 0, 1'b0, 1'b0);
        add_row(100, 0, 1'b0, 1'b0);
        add_row(100, 100, 1'b0, 1'b0);
        add_row(0, 100, 1'b1, 1'b0);
        add_row(50, 50, 1'b1, 1'b0);
        add_row(10, 10, 1'b0, 1'b0);
        add_row(10, 20, 1'b0, 1'b0);
        add_row(20, 10, 1'b1, 1'b1);
        // collinear points
        add_row(0, 0, 1'b0, 1'b0);
        add_row(5, 5, 1'b0, 1'b0);
        add_row(10, 10, 1'b1, 1'b1);
        typed_last(0, 0, 0, 1'b1);
        // far-apart rings of opposite sign: centroid saturates
        add_row(30000, 0, 1'b0, 1'b0);
        add_row(30100, 0, 1'b0, 1'b0);
        add_row(30000, 100, 1'b1, 1'b0);
        add_row(-30000, 0, 1'b0, 1'b0);
        add_row(-30100, 0, 1'b0, 1'b0);
        add_row(-30000, 99, 1'b1, 1'b1);

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i]) push_vertex(dir_rows[i].v, dir_rows[i].typed, dir_rows[i].want);
        drain_results();

        rand_start = items_sent;
        while (items_sent - rand_start < RANDOM_ITEMS) begin
            quiet = (items_sent - rand_start >= 300) && (items_sent - rand_start < 500);
            send_random_set();
        end
        quiet = 1'b0;
        drain_results();

        while (due_centroids.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/pac_pkg.sv
hw/rtl/pac_mul.sv
hw/rtl/pac_div.sv
hw/rtl/polygon_area_centroid_top.sv
test/polygon_area_centroid_top_tb.sv
